>>> hw/rtl/cam_pkg.sv
package cam_pkg;

  // Default sizes of the label tables and of the counters.
  localparam int DEF_MAX_LABELS = 64;
  localparam int DEF_COUNT_BITS = 20;

  // Fraction bits of the fixed-point log2.
  localparam int LOG_FRAC = 24;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_LABELS = 2'd1;
  localparam logic [1:0] ST_ZERO   = 2'd2;
  localparam logic [1:0] ST_OVF    = 2'd3;

  // One point: a pair of labels and the end-of-set mark.
  typedef struct packed {
    logic signed [31:0] label_a;
    logic signed [31:0] label_b;
    logic               last_point;
  } in_item_t;

  // One result: both metrics in signed Q2.30 and a status.
  typedef struct packed {
    logic signed [31:0] ari;
    logic signed [31:0] nmi;
    logic [1:0]         status;
  } out_item_t;

endpackage

>>> hw/rtl/cam_mul.sv
// Sequential 64x64 multiplier: one 32x32 partial product per cycle,
// each registered before it is added into the 128-bit sum.
module cam_mul import cam_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);

  logic [63:0]  a_r, b_r;
  logic [1:0]   cnt_r;
  logic         run_r;
  logic [63:0]  pp_r;
  logic [1:0]   sh_r;
  logic         pv_r;
  logic [127:0] acc_r;
  logic         done_r;
  logic [31:0]  pa, pb;
  logic [127:0] pp_sh;

  // Operand halves for the current partial product.
  assign pa = cnt_r[1] ? a_r[63:32] : a_r[31:0];
  assign pb = cnt_r[0] ? b_r[63:32] : b_r[31:0];

  // Place the registered partial product at its weight.
  always_comb begin
    case (sh_r)
      2'd0:    pp_sh = {64'd0, pp_r};
      2'd3:    pp_sh = {pp_r, 64'd0};
      default: pp_sh = {32'd0, pp_r, 32'd0};
    endcase
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= pv_r && (sh_r == 2'd3);
      pv_r   <= run_r;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 2'd0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + pp_sh;
    end
    pp_r <= pa * pb;
    sh_r <= cnt_r;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

>>> hw/rtl/cam_div.sv
// Restoring divider for a Q2.30 quotient: 32 quotient bits one per cycle,
// then round half away from zero, saturate and apply the sign.
module cam_div import cam_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] mag,
  input  logic [127:0] den,
  input  logic         neg,
  output logic         done,
  output logic [31:0]  quo
);

  logic [127:0] rem_r, den_r, r_sh;
  logic [31:0]  q_r, q_nx, u_r, quo_r;
  logic [5:0]   cnt_r;
  logic         run_r, rnd_r, neg_r, done_r, ge;
  logic [32:0]  q_up;

  // One quotient digit: shift the remainder except on the first step.
  assign r_sh = (cnt_r == 6'd0) ? rem_r : {rem_r[126:0], 1'b0};
  assign ge   = r_sh >= den_r;
  assign q_nx = {q_r[30:0], ge};
  assign q_up = ({1'b0, q_nx} + 33'd1) >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= mag;
        den_r <= den;
        neg_r <= neg;
        q_r   <= '0;
        cnt_r <= '0;
        // A quotient of two or more saturates at once.
        if (mag >= {den[126:0], 1'b0}) begin
          u_r   <= 32'h8000_0000;
          rnd_r <= 1'b1;
        end else begin
          run_r <= 1'b1;
        end
      end else if (run_r) begin
        rem_r <= ge ? r_sh - den_r : r_sh;
        q_r   <= q_nx;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          run_r <= 1'b0;
          u_r   <= q_up[31:0];
          rnd_r <= 1'b1;
        end
      end else if (rnd_r) begin
        rnd_r  <= 1'b0;
        done_r <= 1'b1;
        if (!neg_r && u_r[31]) begin
          quo_r <= 32'h7FFF_FFFF;
        end else if (neg_r) begin
          quo_r <= 32'd0 - u_r;
        end else begin
          quo_r <= u_r;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> hw/rtl/clustering_agreement_metrics_top.sv
// Clustering agreement metrics. Each point (a pair of labels) is taken when
// start is high and busy is low. In the cycle it is taken both labels are
// matched against the label tables and the cell, row and column counts are
// read; the write-back state follows, with busy high, so no new point is
// taken until it is done. The point marked last_point starts the final
// pass, which walks every used cell, row and column in the single-port
// count memories (reading and clearing them), forms the binomial sums and
// the count-times-log2 sums with one shared sequential multiplier (26
// products and a normalizing shift of up to 31 bit positions per nonzero
// count), and ends with at most two serial divisions. The result then
// appears on out_item for exactly one cycle with out_valid high; it cannot
// be held off. After reset the block clears the count memories, one cell
// entry a cycle, over all 2^(2*ceil(log2 MAX_LABELS)) cell entries (4096
// by default), with busy high.
module clustering_agreement_metrics_top import cam_pkg::*; #(
  parameter int MAX_LABELS = DEF_MAX_LABELS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_item,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int IW    = $clog2(MAX_LABELS);
  localparam int CW    = IW + 1;
  localparam int CB    = COUNT_BITS;
  localparam int ROWS  = 1 << IW;
  localparam int CELLS = 1 << (2 * IW);

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_UPD  = 5'd2;
  localparam logic [4:0] S_NEXT = 5'd3;
  localparam logic [4:0] S_RD   = 5'd4;
  localparam logic [4:0] S_VAL  = 5'd5;
  localparam logic [4:0] S_HAVE = 5'd6;
  localparam logic [4:0] S_C2W  = 5'd7;
  localparam logic [4:0] S_NORM = 5'd8;
  localparam logic [4:0] S_SQW  = 5'd9;
  localparam logic [4:0] S_VLW  = 5'd10;
  localparam logic [4:0] S_ADV  = 5'd11;
  localparam logic [4:0] S_Y    = 5'd12;
  localparam logic [4:0] S_YW   = 5'd13;
  localparam logic [4:0] S_DW   = 5'd14;
  localparam logic [4:0] S_XW   = 5'd15;
  localparam logic [4:0] S_AD   = 5'd16;
  localparam logic [4:0] S_ADW  = 5'd17;
  localparam logic [4:0] S_NM   = 5'd18;
  localparam logic [4:0] S_NMW  = 5'd19;
  localparam logic [4:0] S_OUT  = 5'd20;

  // What the final pass is walking; also selects the accumulator pair.
  localparam logic [1:0] K_CELL = 2'd0;
  localparam logic [1:0] K_ROW  = 2'd1;
  localparam logic [1:0] K_COL  = 2'd2;
  localparam logic [1:0] K_N    = 2'd3;

  localparam logic [CB-1:0] LIM = {CB{1'b1}};

  logic [4:0]    st_r;
  logic [2*IW-1:0] clr_r;

  // Label tables, counts and load-phase registers.
  logic [31:0]   tab_a_r [MAX_LABELS];
  logic [31:0]   tab_b_r [MAX_LABELS];
  logic [CW-1:0] cnt_a_r, cnt_b_r;
  logic [CB-1:0] pc_r;
  logic [1:0]    err_r;
  logic [IW-1:0] ia_r, ib_r, idx_a, idx_b;
  logic          na_r, nb_r, hit_a, hit_b, last_r;
  logic [31:0]   la_r, lb_r;
  logic          full, ovf, upd_ok;

  // Count memories.
  logic [CB-1:0]   cell_mem [CELLS];
  logic [CB-1:0]   row_mem  [ROWS];
  logic [CB-1:0]   col_mem  [ROWS];
  logic [2*IW-1:0] cell_addr;
  logic [IW-1:0]   row_addr, col_addr;
  logic            cell_we, row_we, col_we;
  logic [CB-1:0]   cell_wd, row_wd, col_wd;
  logic [CB-1:0]   cell_rd_r, row_rd_r, col_rd_r;

  // Final pass.
  logic [1:0]    kind_r;
  logic [CW-1:0] i_r, j_r;
  logic [CB-1:0] v_r;
  logic [31:0]   m_r;
  logic [4:0]    e_r, fc_r;
  logic [LOG_FRAC-1:0] fr_r, fr_nx;
  logic [32:0]   sq;
  logic [31:0]   m_nx;
  logic [63:0]   c2_r [4];
  logic [63:0]   lg_r [4];
  logic [127:0]  y_r, dn_r, x_r;
  logic [31:0]   ari_r, nmi_r;
  logic          zero_r;
  logic [63:0]   bc, nl2, p_s, q_s;

  // Shared arithmetic units.
  logic          mul_go_r, mul_done;
  logic [63:0]   mul_a_r, mul_b_r;
  logic [127:0]  mul_p;
  logic          div_go_r, div_done, div_neg_r;
  logic [127:0]  div_mag_r, div_den_r;
  logic [31:0]   div_q;

  logic          out_valid_r;
  out_item_t     out_item_r;

  cam_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .done  (mul_done),
    .prod  (mul_p)
  );

  cam_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .mag   (div_mag_r),
    .den   (div_den_r),
    .neg   (div_neg_r),
    .done  (div_done),
    .quo   (div_q)
  );

  assign busy = (st_r != S_IDLE);

  // Associative label match; the lowest matching entry wins.
  always_comb begin
    hit_a = 1'b0;
    hit_b = 1'b0;
    idx_a = cnt_a_r[IW-1:0];
    idx_b = cnt_b_r[IW-1:0];
    for (int k = MAX_LABELS - 1; k >= 0; k--) begin
      if ((CW'(k) < cnt_a_r) && (tab_a_r[k] == in_item.label_a)) begin
        hit_a = 1'b1;
        idx_a = IW'(k);
      end
      if ((CW'(k) < cnt_b_r) && (tab_b_r[k] == in_item.label_b)) begin
        hit_b = 1'b1;
        idx_b = IW'(k);
      end
    end
  end

  // Write-back checks for the point in flight.
  assign full = (na_r && (cnt_a_r >= CW'(MAX_LABELS))) ||
                (nb_r && (cnt_b_r >= CW'(MAX_LABELS)));
  assign ovf  = (pc_r == LIM) || (row_rd_r == LIM) || (col_rd_r == LIM) ||
                (cell_rd_r == LIM);
  assign upd_ok = (err_r == ST_OK) && !full && !ovf;

  // Memory port addresses and writes.
  always_comb begin
    cell_addr = {i_r[IW-1:0], j_r[IW-1:0]};
    row_addr  = i_r[IW-1:0];
    col_addr  = j_r[IW-1:0];
    cell_we   = 1'b0;
    row_we    = 1'b0;
    col_we    = 1'b0;
    cell_wd   = '0;
    row_wd    = '0;
    col_wd    = '0;
    if (st_r == S_CLR) begin
      cell_addr = clr_r;
      row_addr  = clr_r[IW-1:0];
      col_addr  = clr_r[IW-1:0];
      cell_we   = 1'b1;
      row_we    = 1'b1;
      col_we    = 1'b1;
    end else if (st_r == S_IDLE) begin
      cell_addr = {idx_a, idx_b};
      row_addr  = idx_a;
      col_addr  = idx_b;
    end else if (st_r == S_UPD) begin
      cell_addr = {ia_r, ib_r};
      row_addr  = ia_r;
      col_addr  = ib_r;
      cell_we   = upd_ok;
      row_we    = upd_ok;
      col_we    = upd_ok;
      cell_wd   = cell_rd_r + CB'(1);
      row_wd    = row_rd_r + CB'(1);
      col_wd    = col_rd_r + CB'(1);
    end else if (st_r == S_RD) begin
      // The final pass clears each entry as it reads it.
      cell_we = (kind_r == K_CELL);
      row_we  = (kind_r == K_ROW);
      col_we  = (kind_r == K_COL);
    end
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_addr] <= cell_wd;
    end
    cell_rd_r <= cell_mem[cell_addr];
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_addr] <= row_wd;
    end
    row_rd_r <= row_mem[row_addr];
  end

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[col_addr] <= col_wd;
    end
    col_rd_r <= col_mem[col_addr];
  end

  // One squaring step of the log2 digit loop.
  assign sq    = mul_p[63:31];
  assign m_nx  = sq[32] ? sq[32:1] : sq[31:0];
  assign fr_nx = {fr_r[LOG_FRAC-2:0], sq[32]};

  // Sums for the mutual information.
  assign bc  = lg_r[K_ROW] + lg_r[K_COL];
  assign nl2 = {lg_r[K_N][62:0], 1'b0};
  assign p_s = (lg_r[K_CELL] + lg_r[K_N]) << 1;
  assign q_s = bc << 1;

  // Label tables.
  always_ff @(posedge clk) begin
    if (st_r == S_UPD && upd_ok) begin
      if (na_r) begin
        tab_a_r[ia_r] <= la_r;
      end
      if (nb_r) begin
        tab_b_r[ib_r] <= lb_r;
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      clr_r       <= '0;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      pc_r        <= '0;
      err_r       <= ST_OK;
      mul_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mul_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      unique case (st_r)
        S_CLR: begin
          clr_r <= clr_r + (2 * IW)'(1);
          if (&clr_r) begin
            st_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          ia_r   <= idx_a;
          ib_r   <= idx_b;
          na_r   <= !hit_a;
          nb_r   <= !hit_b;
          la_r   <= in_item.label_a;
          lb_r   <= in_item.label_b;
          last_r <= in_item.last_point;
          if (start) begin
            st_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (err_r == ST_OK) begin
            if (full) begin
              err_r <= ST_LABELS;
            end else if (ovf) begin
              err_r <= ST_OVF;
            end else begin
              cnt_a_r <= cnt_a_r + CW'(na_r);
              cnt_b_r <= cnt_b_r + CW'(nb_r);
              pc_r    <= pc_r + CB'(1);
            end
          end
          if (last_r) begin
            kind_r <= K_CELL;
            i_r    <= '0;
            j_r    <= '0;
            zero_r <= 1'b0;
            for (int k = 0; k < 4; k++) begin
              c2_r[k] <= '0;
              lg_r[k] <= '0;
            end
            st_r <= S_NEXT;
          end else begin
            st_r <= S_IDLE;
          end
        end
        S_NEXT: begin
          case (kind_r)
            K_CELL: begin
              if (i_r < cnt_a_r && j_r < cnt_b_r) begin
                st_r <= S_RD;
              end else begin
                kind_r <= K_ROW;
                i_r    <= '0;
                j_r    <= '0;
              end
            end
            K_ROW: begin
              if (i_r < cnt_a_r) begin
                st_r <= S_RD;
              end else begin
                kind_r <= K_COL;
                j_r    <= '0;
              end
            end
            K_COL: begin
              if (j_r < cnt_b_r) begin
                st_r <= S_RD;
              end else begin
                kind_r <= K_N;
                v_r    <= pc_r;
                st_r   <= S_HAVE;
              end
            end
            default: begin
              v_r  <= pc_r;
              st_r <= S_HAVE;
            end
          endcase
        end
        S_RD: begin
          st_r <= S_VAL;
        end
        S_VAL: begin
          case (kind_r)
            K_CELL:  v_r <= cell_rd_r;
            K_ROW:   v_r <= row_rd_r;
            default: v_r <= col_rd_r;
          endcase
          st_r <= S_HAVE;
        end
        S_HAVE: begin
          // A zero count adds nothing to either sum.
          if (v_r == '0) begin
            st_r <= S_ADV;
          end else begin
            mul_a_r  <= 64'(v_r);
            mul_b_r  <= 64'(v_r) - 64'd1;
            mul_go_r <= 1'b1;
            st_r     <= S_C2W;
          end
        end
        S_C2W: begin
          if (mul_done) begin
            c2_r[kind_r] <= c2_r[kind_r] + mul_p[64:1];
            m_r          <= 32'(v_r);
            e_r          <= 5'd31;
            st_r         <= S_NORM;
          end
        end
        S_NORM: begin
          // Shift the count up to the top bit to find its exponent.
          if (m_r[31]) begin
            fc_r     <= '0;
            fr_r     <= '0;
            mul_a_r  <= 64'(m_r);
            mul_b_r  <= 64'(m_r);
            mul_go_r <= 1'b1;
            st_r     <= S_SQW;
          end else begin
            m_r <= {m_r[30:0], 1'b0};
            e_r <= e_r - 5'd1;
          end
        end
        S_SQW: begin
          if (mul_done) begin
            m_r      <= m_nx;
            fr_r     <= fr_nx;
            fc_r     <= fc_r + 5'd1;
            mul_go_r <= 1'b1;
            if (fc_r == 5'(LOG_FRAC - 1)) begin
              mul_a_r <= 64'(v_r);
              mul_b_r <= 64'({e_r, fr_nx});
              st_r    <= S_VLW;
            end else begin
              mul_a_r <= 64'(m_nx);
              mul_b_r <= 64'(m_nx);
            end
          end
        end
        S_VLW: begin
          if (mul_done) begin
            lg_r[kind_r] <= lg_r[kind_r] + mul_p[63:0];
            st_r         <= S_ADV;
          end
        end
        S_ADV: begin
          case (kind_r)
            K_CELL: begin
              if ((j_r + CW'(1)) < cnt_b_r) begin
                j_r <= j_r + CW'(1);
              end else begin
                j_r <= '0;
                i_r <= i_r + CW'(1);
              end
              st_r <= S_NEXT;
            end
            K_ROW: begin
              i_r  <= i_r + CW'(1);
              st_r <= S_NEXT;
            end
            K_COL: begin
              j_r  <= j_r + CW'(1);
              st_r <= S_NEXT;
            end
            default: st_r <= S_Y;
          endcase
        end
        S_Y: begin
          mul_a_r  <= c2_r[K_ROW];
          mul_b_r  <= c2_r[K_COL];
          mul_go_r <= 1'b1;
          st_r     <= S_YW;
        end
        S_YW: begin
          if (mul_done) begin
            y_r      <= {mul_p[126:0], 1'b0};
            mul_a_r  <= c2_r[K_ROW] + c2_r[K_COL];
            mul_b_r  <= c2_r[K_N];
            mul_go_r <= 1'b1;
            st_r     <= S_DW;
          end
        end
        S_DW: begin
          if (mul_done) begin
            dn_r     <= mul_p - y_r;
            mul_a_r  <= c2_r[K_CELL];
            mul_b_r  <= c2_r[K_N];
            mul_go_r <= 1'b1;
            st_r     <= S_XW;
          end
        end
        S_XW: begin
          if (mul_done) begin
            x_r  <= {mul_p[126:0], 1'b0};
            st_r <= S_AD;
          end
        end
        S_AD: begin
          if (dn_r == '0) begin
            ari_r  <= '0;
            zero_r <= 1'b1;
            st_r   <= S_NM;
          end else begin
            div_mag_r <= (x_r >= y_r) ? x_r - y_r : y_r - x_r;
            div_den_r <= dn_r;
            div_neg_r <= !(x_r >= y_r);
            div_go_r  <= 1'b1;
            st_r      <= S_ADW;
          end
        end
        S_ADW: begin
          if (div_done) begin
            ari_r <= div_q;
            st_r  <= S_NM;
          end
        end
        S_NM: begin
          if (bc >= nl2) begin
            nmi_r  <= '0;
            zero_r <= 1'b1;
            st_r   <= S_OUT;
          end else begin
            div_mag_r <= {64'd0, (p_s >= q_s) ? p_s - q_s : q_s - p_s};
            div_den_r <= {64'd0, nl2 - bc};
            div_neg_r <= !(p_s >= q_s);
            div_go_r  <= 1'b1;
            st_r      <= S_NMW;
          end
        end
        S_NMW: begin
          if (div_done) begin
            nmi_r <= div_q;
            st_r  <= S_OUT;
          end
        end
        S_OUT: begin
          // Present the result and start a new data set.
          out_valid_r <= 1'b1;
          if (err_r != ST_OK) begin
            out_item_r.ari    <= '0;
            out_item_r.nmi    <= '0;
            out_item_r.status <= err_r;
          end else begin
            out_item_r.ari    <= ari_r;
            out_item_r.nmi    <= nmi_r;
            out_item_r.status <= zero_r ? ST_ZERO : ST_OK;
          end
          cnt_a_r <= '0;
          cnt_b_r <= '0;
          pc_r    <= '0;
          err_r   <= ST_OK;
          st_r    <= S_IDLE;
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A result only follows the output state.
  a_out_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(st_r) == S_OUT)
    else $error("result strobe without a finished pass");

  // An accepted point always goes to its write-back cycle.
  a_accept_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> st_r == S_UPD)
    else $error("accepted point skipped write-back");

  // The label counts never pass the table size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_a_r <= CW'(MAX_LABELS) && cnt_b_r <= CW'(MAX_LABELS))
    else $error("label count beyond table size");

  // An error result carries zero metrics.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == ST_LABELS || out_item.status == ST_OVF))
      |-> (out_item.ari == 32'sd0 && out_item.nmi == 32'sd0))
    else $error("error result with nonzero metrics");

endmodule

>>> bench/cam_checker.sv
// Watches both channels of the clustering agreement block, keeps its own copy of
// the label tables and count stores, predicts each result and compares it.
module cam_checker import cam_pkg::*; #(
  parameter int MAX_LABELS = DEF_MAX_LABELS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_item,
  input  logic      busy,
  input  logic      out_valid,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending
);

  localparam logic [63:0] COUNT_LIM = (64'd1 << COUNT_BITS) - 64'd1;

  // Predicted contents of the block.
  logic [31:0] tab_a [MAX_LABELS];
  logic [31:0] tab_b [MAX_LABELS];
  int          used_a, used_b;
  logic [63:0] cell_cnt [MAX_LABELS][MAX_LABELS];
  logic [63:0] row_cnt [MAX_LABELS];
  logic [63:0] col_cnt [MAX_LABELS];
  logic [63:0] n_points;
  logic [1:0]  err_code;

  out_item_t metrics_due [$];

  assign pending = metrics_due.size();

  function automatic logic [63:0] pairs_of(input logic [63:0] x);
    return (x == 0) ? 64'd0 : x * (x - 64'd1) / 64'd2;
  endfunction

  // Integer part is the top set bit; the fraction comes from repeated squaring.
  function automatic logic [63:0] log2_q24(input logic [63:0] x);
    logic [63:0] m;
    logic [63:0] frac;
    int e;
    frac = 0;
    if (x == 0) return 64'd0;
    e = 31;
    while (e > 0 && !x[e]) e--;
    m = x << (31 - e);
    for (int i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'(e) << LOG_FRAC) | frac;
  endfunction

  // Rounded, saturated Q2.30 quotient of a magnitude with a sign.
  function automatic logic [31:0] q30_quot(input logic [127:0] mag, input logic [127:0] den,
                                           input bit neg);
    logic [63:0] q;
    logic [63:0] res;
    q = 0;
    if (mag >= (den << 1)) begin
      res = 64'd1 << 31;
    end else begin
      for (int i = 0; i < 32; i++) begin
        if (i > 0) mag = mag << 1;
        q = q << 1;
        if (mag >= den) begin
          mag = mag - den;
          q = q | 64'd1;
        end
      end
      res = (q + 64'd1) >> 1;
    end
    if (!neg && res > 64'h7FFF_FFFF) res = 64'h7FFF_FFFF;
    if (neg) res = 64'd0 - res;
    return res[31:0];
  endfunction

  // ARI from the pair counts and NMI from the count-times-log2 sums.
  function automatic out_item_t agreement_of();
    out_item_t r;
    logic [63:0] sc, s1, s2, t, sa, sb, sc_log, nl, p, q;
    logic [127:0] x, y, den;
    sc = 0; s1 = 0; s2 = 0; sa = 0; sb = 0; sc_log = 0;
    r.status = ST_OK;
    for (int i = 0; i < used_a; i++) begin
      for (int j = 0; j < used_b; j++) begin
        sc = sc + pairs_of(cell_cnt[i][j]);
        sa = sa + cell_cnt[i][j] * log2_q24(cell_cnt[i][j]);
      end
      s1 = s1 + pairs_of(row_cnt[i]);
      sb = sb + row_cnt[i] * log2_q24(row_cnt[i]);
    end
    for (int j = 0; j < used_b; j++) begin
      s2 = s2 + pairs_of(col_cnt[j]);
      sc_log = sc_log + col_cnt[j] * log2_q24(col_cnt[j]);
    end
    t = pairs_of(n_points);
    y = (128'(s1) * 128'(s2)) << 1;
    den = 128'(s1 + s2) * 128'(t) - y;
    x = (128'(sc) * 128'(t)) << 1;
    if (den == 0) begin
      r.ari = 0;
      r.status = ST_ZERO;
    end else if (x >= y) begin
      r.ari = q30_quot(x - y, den, 1'b0);
    end else begin
      r.ari = q30_quot(y - x, den, 1'b1);
    end
    nl = n_points * log2_q24(n_points);
    p = 64'd2 * (sa + nl);
    q = 64'd2 * (sb + sc_log);
    if (sb + sc_log >= 64'd2 * nl) begin
      r.nmi = 0;
      r.status = ST_ZERO;
    end else if (p >= q) begin
      r.nmi = q30_quot(128'(p - q), 128'(64'd2 * nl - (sb + sc_log)), 1'b0);
    end else begin
      r.nmi = q30_quot(128'(q - p), 128'(64'd2 * nl - (sb + sc_log)), 1'b1);
    end
    return r;
  endfunction

  task automatic clear_stores();
    used_a = 0;
    used_b = 0;
    n_points = 0;
    err_code = ST_OK;
    for (int i = 0; i < MAX_LABELS; i++) begin
      row_cnt[i] = 0;
      col_cnt[i] = 0;
      for (int j = 0; j < MAX_LABELS; j++) cell_cnt[i][j] = 0;
    end
  endtask

  // Count one point and, on the last point, queue the expected result.
  task automatic count_point(input in_item_t it);
    int ia, ib;
    out_item_t r;
    ia = used_a;
    ib = used_b;
    if (err_code == ST_OK) begin
      for (int i = 0; i < used_a; i++) if (tab_a[i] == it.label_a && ia == used_a) ia = i;
      for (int j = 0; j < used_b; j++) if (tab_b[j] == it.label_b && ib == used_b) ib = j;
      if ((ia == used_a && used_a >= MAX_LABELS) || (ib == used_b && used_b >= MAX_LABELS)) begin
        err_code = ST_LABELS;
      end else if (n_points >= COUNT_LIM || row_cnt[ia] >= COUNT_LIM ||
                   col_cnt[ib] >= COUNT_LIM || cell_cnt[ia][ib] >= COUNT_LIM) begin
        err_code = ST_OVF;
      end else begin
        if (ia == used_a) begin
          tab_a[ia] = it.label_a;
          used_a++;
        end
        if (ib == used_b) begin
          tab_b[ib] = it.label_b;
          used_b++;
        end
        cell_cnt[ia][ib]++;
        row_cnt[ia]++;
        col_cnt[ib]++;
        n_points++;
      end
    end
    if (it.last_point) begin
      if (err_code != ST_OK) begin
        r.ari = 0;
        r.nmi = 0;
        r.status = err_code;
      end else begin
        r = agreement_of();
      end
      metrics_due.push_back(r);
      clear_stores();
    end
  endtask

  initial begin
    fail_count = 0;
    clear_stores();
  end

  // Compare results first, then account for the transaction taken at this edge.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (metrics_due.size() == 0) begin
          $error("result with no expectation: ari %0d nmi %0d status %0d",
                 out_item.ari, out_item.nmi, out_item.status);
          fail_count++;
        end else begin
          want = metrics_due.pop_front();
          if (out_item.ari !== want.ari) begin
            $error("ari: expected %0d, got %0d", want.ari, out_item.ari);
            fail_count++;
          end
          if (out_item.nmi !== want.nmi) begin
            $error("nmi: expected %0d, got %0d", want.nmi, out_item.nmi);
            fail_count++;
          end
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            fail_count++;
          end
        end
      end
      if (start && !busy) count_point(in_item);
    end
  end

endmodule

>>> bench/tb_clustering_agreement_metrics_top.sv
// Drives data sets of labeled points into the block and gives the verdict.
module tb_clustering_agreement_metrics_top;
  import cam_pkg::*;

  localparam int CYCLE_LIMIT = 40_000_000;

  logic      clk;
  logic      rst_n;
  logic      start;
  in_item_t  in_item;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  int        cycles;
  int        points_sent;
  bit        no_gaps;

  clustering_agreement_metrics_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item),
    .busy(busy), .out_valid(out_valid), .out_item(out_item)
  );

  cam_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item), .busy(busy),
    .out_valid(out_valid), .out_item(out_item), .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Cycle counter with the timeout.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_clustering_agreement_metrics_top NOT OK");
      $finish;
    end
  end

  // Offer one point and hold it until the block takes the transaction.
  task automatic send_point(input logic [31:0] la, input logic [31:0] lb, input bit last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_item <= '{label_a: la, label_b: lb, last_point: last};
    do @(posedge clk); while (busy);
    points_sent++;
  endtask

  // A random data set drawn from label pools (mostly small) around random bases, with an occasional fully random label.
  task automatic send_random_set();
    int size, pool_a, pool_b;
    logic [31:0] base_a, base_b;
    if ($urandom_range(0, 24) == 0) begin
      size = $urandom_range(60, 72);
      pool_a = $urandom_range(50, 90);
      pool_b = $urandom_range(2, 90);
    end else begin
      size = $urandom_range(1, 24);
      pool_a = $urandom_range(1, 8);
      pool_b = $urandom_range(1, 8);
    end
    base_a = $urandom;
    base_b = $urandom;
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < size; i++) begin
      if ($urandom_range(0, 15) == 0)
        send_point($urandom, $urandom, i == size - 1);
      else
        send_point(base_a + $urandom_range(0, pool_a - 1),
                   base_b + $urandom_range(0, pool_b - 1), i == size - 1);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    points_sent = 0;
    no_gaps = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Extreme labels in both clusterings.
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_point(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_point(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    // A single point: both denominators are zero.
    send_point(32'h5, 32'h9, 1'b1);
    // One cluster in both clusterings.
    for (int i = 0; i < 4; i++) send_point(32'h7, 32'h3, i == 3);
    // All singletons in both clusterings.
    for (int i = 0; i < 4; i++) send_point(i, 100 + i, i == 3);
    // Identical and then opposed partitions.
    for (int i = 0; i < 6; i++) send_point(i % 2, i % 2, i == 5);
    for (int i = 0; i < 6; i++) send_point(i % 2, i / 3, i == 5);

    // Too many labels in the first clustering, then points after the error.
    for (int i = 0; i < 68; i++) send_point(1000 + i, 7, i == 67);
    // Too many labels in the second clustering.
    for (int i = 0; i < 66; i++) send_point(-5, -1000 - i, i == 65);

    // Random data sets.
    while (points_sent < 1050) send_random_set();

    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_clustering_agreement_metrics_top OK");
    end else begin
      $display("tb_clustering_agreement_metrics_top NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/cam_pkg.sv
hw/rtl/cam_mul.sv
hw/rtl/cam_div.sv
hw/rtl/clustering_agreement_metrics_top.sv
bench/cam_checker.sv
bench/tb_clustering_agreement_metrics_top.sv
